@@ rtl/lmb_pkg.sv @@
package lmb_pkg;

  // Register indexes on the write port.
  localparam logic [2:0] REG_METER_MODE     = 3'd0;
  localparam logic [2:0] REG_FLOOR_LEVEL    = 3'd1;
  localparam logic [2:0] REG_RELEASE_STEP   = 3'd2;
  localparam logic [2:0] REG_PEAK_HOLD      = 3'd3;
  localparam logic [2:0] REG_PEAK_DECAY     = 3'd4;
  localparam logic [2:0] REG_AVERAGE_COEF   = 3'd5;
  localparam logic [2:0] REG_CLIP_HOLD      = 3'd6;

  localparam int unsigned REG_INDEX_BITS = 3;
  localparam int unsigned REG_DATA_BITS  = 16;

  localparam logic [1:0] MODE_PEAK = 2'd0;

  // 20*log10(2) in Q.16, and the reciprocal of the fraction of full scale at or below which a level reads as the floor.
  localparam int unsigned DB_PER_OCTAVE_Q16 = 394566;
  localparam int unsigned Micro_Recip       = 1000000;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [1:0]         meter_mode;
    logic signed [15:0] floor_level;
    logic [14:0]        release_step;
    logic [15:0]        peak_hold_ticks;
    logic [14:0]        peak_decay_step;
    logic [15:0]        average_coefficient;
    logic [15:0]        clip_hold_ticks;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    meter_mode:          2'd1,
    floor_level:         -16'sd15360,
    release_step:        15'd256,
    peak_hold_ticks:     16'd30,
    peak_decay_step:     15'd128,
    average_coefficient: 16'd58982,
    clip_hold_ticks:     16'd60
  };

  // A converted request on its way from the front to the back.
  typedef struct packed {
    logic               clear;
    logic               over;
    logic signed [15:0] db;
  } item_t;

  typedef struct packed {
    logic signed [15:0] bar_level;
    logic signed [15:0] peak_level;
    logic               clip_on;
    logic               changed;
  } result_t;

  // log2 of a Q2.30 mantissa in [1,2) to 16 fraction bits, by repeated squaring.
  // Only ever evaluated on constants to build the lookup table.
  function automatic logic [15:0] log2_frac(input logic [63:0] x0);
    logic [63:0] x;
    logic [15:0] r;
    x = x0;
    r = '0;
    for (int k = 0; k < 16; k++) begin
      x = (x * x) >> 30;
      r = {r[14:0], 1'b0};
      if (x >= 64'h8000_0000) begin
        r[0] = 1'b1;
        x = x >> 1;
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/lmb_queue.sv @@
module lmb_queue #(
  parameter int unsigned WIDTH = 18,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/lmb_front.sv @@
module lmb_front #(
  parameter int unsigned LEVEL_BITS      = 24,
  parameter int unsigned LOG_TABLE_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic                  op,
  input  logic [LEVEL_BITS-1:0] level,
  input  logic signed [15:0]    floor_level,
  output logic                  item_push,
  output lmb_pkg::item_t        item,
  input  logic                  item_full
);

  import lmb_pkg::*;

  localparam int unsigned LB   = LEVEL_BITS;
  localparam int unsigned FRAC = LEVEL_BITS - 2;
  localparam int unsigned PW   = $clog2(LEVEL_BITS);
  localparam int unsigned IW   = $clog2(LOG_TABLE_DEPTH);
  localparam int unsigned SW   = LEVEL_BITS + IW + 1;
  localparam int unsigned L2W  = PW + 17;
  localparam int unsigned EW   = L2W - 16;
  localparam int unsigned MW   = L2W + 21;

  localparam logic [63:0] LOW_LIMIT = (64'd1 << FRAC) / 64'(Micro_Recip);
  localparam logic signed [20:0] OCT_GAIN = 21'(DB_PER_OCTAVE_Q16);
  localparam logic signed [MW-1:0] HALF   = MW'(1) << 23;
  localparam logic signed [MW-1:0] SAT_HI = MW'(32767);
  localparam logic signed [MW-1:0] SAT_LO = -MW'(32768);

  logic [15:0] log_tab [LOG_TABLE_DEPTH];

  for (genvar g = 0; g < LOG_TABLE_DEPTH; g++) begin : g_tab
    localparam logic [63:0] X0 = (64'd1 << 30) + ((64'(g) << 30) / 64'(LOG_TABLE_DEPTH));
    assign log_tab[g] = log2_frac(X0);
  end

  logic [4:0] valid;
  logic       adv;
  logic       accept;

  logic          s1_op;
  logic [LB-1:0] s1_level;

  logic          s2_op, s2_low, s2_over;
  logic [PW-1:0] s2_lead;
  logic [LB-1:0] s2_frac;

  logic          s3_op, s3_low, s3_over;
  logic [PW-1:0] s3_lead;
  logic [IW-1:0] s3_idx;

  logic                  s4_op, s4_low, s4_over;
  logic signed [L2W-1:0] s4_l2;

  logic                 s5_op, s5_low, s5_over;
  logic signed [MW-1:0] s5_prod;

  logic [PW-1:0]         lead;
  logic [SW-1:0]         scaled;
  logic [SW-1:0]         shifted;
  logic [IW-1:0]         idx_next;
  logic signed [EW-1:0]  expo;
  logic signed [L2W-1:0] l2_next;
  logic signed [MW-1:0]  rounded;
  logic signed [MW-1:0]  db_wide;
  logic signed [15:0]    db_sat;
  logic signed [15:0]    db;

  // The whole pipeline moves together; it only stops when the last stage holds a
  // request the queue cannot take.
  assign adv    = !(valid[4] && item_full);
  assign full   = !adv;
  assign accept = push && adv;

  always_comb begin
    lead = '0;
    for (int b = 0; b < LB; b++) begin
      if (s1_level[b]) begin
        lead = PW'(b);
      end
    end
  end

  assign scaled   = SW'(s2_frac) * SW'(LOG_TABLE_DEPTH);
  assign shifted  = scaled >> s2_lead;
  assign idx_next = (shifted >= SW'(LOG_TABLE_DEPTH)) ? IW'(LOG_TABLE_DEPTH - 1)
                                                      : shifted[IW-1:0];

  assign expo    = EW'(s3_lead) - EW'(FRAC);
  assign l2_next = {expo, log_tab[s3_idx]};

  assign rounded = s5_prod + HALF;
  assign db_wide = rounded >>> 24;

  always_comb begin
    if (db_wide > SAT_HI) begin
      db_sat = 16'sd32767;
    end else if (db_wide < SAT_LO) begin
      db_sat = -16'sd32768;
    end else begin
      db_sat = db_wide[15:0];
    end
    if (s5_low || (db_sat < floor_level)) begin
      db = floor_level;
    end else begin
      db = db_sat;
    end
  end

  assign item_push  = valid[4] && !item_full;
  assign item.clear = s5_op;
  assign item.over  = s5_over;
  assign item.db    = db;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (adv) begin
      valid <= {valid[3:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op    <= op;
      s1_level <= level;

      s2_op    <= s1_op;
      s2_low   <= (64'(s1_level) <= LOW_LIMIT);
      s2_over  <= (s1_level[LB-1:FRAC] != '0);
      s2_lead  <= lead;
      s2_frac  <= s1_level & ~(LB'(1) << lead);

      s3_op    <= s2_op;
      s3_low   <= s2_low;
      s3_over  <= s2_over;
      s3_lead  <= s2_lead;
      s3_idx   <= idx_next;

      s4_op    <= s3_op;
      s4_low   <= s3_low;
      s4_over  <= s3_over;
      s4_l2    <= l2_next;

      s5_op    <= s4_op;
      s5_low   <= s4_low;
      s5_over  <= s4_over;
      s5_prod  <= s4_l2 * OCT_GAIN;
    end
  end

endmodule

@@ rtl/lmb_back.sv @@
module lmb_back (
  input  logic             clk,
  input  logic             rst,
  input  lmb_pkg::cfg_t    cfg,
  input  lmb_pkg::item_t   item,
  input  logic             item_empty,
  output logic             item_pop,
  output logic             res_push,
  output lmb_pkg::result_t res,
  input  logic             res_full
);

  import lmb_pkg::*;

  logic               busy;
  item_t              work;
  logic signed [32:0] prod_a;
  logic signed [33:0] prod_b;

  logic signed [15:0] bar_store, bar_next;
  logic signed [15:0] peak_store, peak_next;
  logic [15:0]        hold_counter, hold_counter_next;
  logic [15:0]        clip_counter, clip_counter_next;
  logic               clip_flag, clip_flag_next;

  logic [16:0]        weight_b;
  logic signed [34:0] acc;
  logic signed [18:0] avg;
  logic signed [15:0] avg_sat;
  logic signed [16:0] bar_fall;
  logic signed [16:0] peak_fall;
  logic signed [16:0] floor_wide;

  // A request is taken only when the result queue has room; nothing else fills it.
  assign item_pop = !busy && !item_empty && !res_full;
  assign weight_b = 17'h10000 - 17'(cfg.average_coefficient);

  assign acc = 35'(prod_a) + 35'(prod_b) + 35'(32'sd32768);
  assign avg = acc[34:16];

  assign floor_wide = 17'(cfg.floor_level);
  assign bar_fall   = 17'(bar_store) - 17'(cfg.release_step);
  assign peak_fall  = 17'(peak_store) - 17'(cfg.peak_decay_step);

  always_comb begin
    if (avg > 19'sd32767) begin
      avg_sat = 16'sd32767;
    end else if (avg < -19'sd32768) begin
      avg_sat = -16'sd32768;
    end else begin
      avg_sat = avg[15:0];
    end
  end

  always_comb begin
    bar_next          = bar_store;
    peak_next         = peak_store;
    hold_counter_next = hold_counter;
    clip_counter_next = clip_counter;
    clip_flag_next    = clip_flag;

    if (work.clear) begin
      clip_flag_next    = 1'b0;
      clip_counter_next = '0;
    end else begin
      if (cfg.meter_mode == MODE_PEAK) begin
        if (work.db >= bar_store) begin
          bar_next = work.db;
        end else begin
          bar_next = (bar_fall > floor_wide) ? bar_fall[15:0] : cfg.floor_level;
        end
        if (work.db >= peak_store) begin
          peak_next         = work.db;
          hold_counter_next = cfg.peak_hold_ticks;
        end else if (hold_counter != '0) begin
          hold_counter_next = hold_counter - 1'b1;
        end else begin
          peak_next = (peak_fall > floor_wide) ? peak_fall[15:0] : cfg.floor_level;
        end
      end else begin
        bar_next  = (avg_sat > cfg.floor_level) ? avg_sat : cfg.floor_level;
        peak_next = cfg.floor_level;
      end

      if (work.over) begin
        clip_flag_next    = 1'b1;
        clip_counter_next = cfg.clip_hold_ticks;
      end else if (clip_counter != '0) begin
        clip_counter_next = clip_counter - 1'b1;
        if (clip_counter == 16'd1) begin
          clip_flag_next = 1'b0;
        end
      end
    end
  end

  assign res_push       = busy;
  assign res.bar_level  = bar_next;
  assign res.peak_level = peak_next;
  assign res.clip_on    = clip_flag_next;
  assign res.changed    = (bar_next != bar_store) || (peak_next != peak_store) ||
                          (clip_flag_next != clip_flag);

  always_ff @(posedge clk) begin
    if (item_pop) begin
      work   <= item;
      prod_a <= signed'({1'b0, cfg.average_coefficient}) * bar_store;
      prod_b <= signed'({1'b0, weight_b}) * item.db;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      bar_store    <= CFG_RESET.floor_level;
      peak_store   <= CFG_RESET.floor_level;
      hold_counter <= '0;
      clip_counter <= '0;
      clip_flag    <= 1'b0;
    end else if (busy) begin
      busy         <= 1'b0;
      bar_store    <= bar_next;
      peak_store   <= peak_next;
      hold_counter <= hold_counter_next;
      clip_counter <= clip_counter_next;
      clip_flag    <= clip_flag_next;
    end else if (item_pop) begin
      busy <= 1'b1;
    end
  end

endmodule

@@ rtl/level_meter_ballistics.sv @@
// Level meter with peak-hold and averaging ballistics. Requests go in through a
// queue-style push/full port and results come out through an empty/pop port, one
// result per request in request order. A five-stage conversion pipeline turns the
// linear level into dB and can take a request every cycle unless its last stage is
// stalled; the ballistics unit behind it handles each request by a multiply and
// then an update of the bar, peak and clip state, and takes no new request until
// that update is done. Two-entry queues sit between the conversion and the
// ballistics and in front of the result port. Register writes take effect at once
// and are meant for times when no request is in flight.
module level_meter_ballistics #(
  parameter int unsigned LEVEL_BITS      = 24,
  parameter int unsigned LOG_TABLE_DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic                                op,
  input  logic [LEVEL_BITS-1:0]               level,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [15:0]                  bar_level,
  output logic signed [15:0]                  peak_level,
  output logic                                clip_on,
  output logic                                changed,
  input  logic                                wr_en,
  input  logic [lmb_pkg::REG_INDEX_BITS-1:0]  wr_index,
  input  logic [lmb_pkg::REG_DATA_BITS-1:0]   wr_data
);

  import lmb_pkg::*;

  cfg_t    cfg;
  item_t   item_in;
  item_t   item_out;
  logic    item_push, item_full, item_pop, item_empty;
  result_t res_in;
  result_t res_out;
  logic    res_push, res_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_METER_MODE:   cfg.meter_mode          <= wr_data[1:0];
        REG_FLOOR_LEVEL:  cfg.floor_level         <= signed'(wr_data);
        REG_RELEASE_STEP: cfg.release_step        <= wr_data[14:0];
        REG_PEAK_HOLD:    cfg.peak_hold_ticks     <= wr_data;
        REG_PEAK_DECAY:   cfg.peak_decay_step     <= wr_data[14:0];
        REG_AVERAGE_COEF: cfg.average_coefficient <= wr_data;
        REG_CLIP_HOLD:    cfg.clip_hold_ticks     <= wr_data;
        default: begin
        end
      endcase
    end
  end

  lmb_front #(
    .LEVEL_BITS      (LEVEL_BITS),
    .LOG_TABLE_DEPTH (LOG_TABLE_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .op          (op),
    .level       (level),
    .floor_level (cfg.floor_level),
    .item_push   (item_push),
    .item        (item_in),
    .item_full   (item_full)
  );

  lmb_queue #(
    .WIDTH ($bits(item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_item_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (item_push),
    .din   (item_in),
    .full  (item_full),
    .pop   (item_pop),
    .dout  (item_out),
    .empty (item_empty)
  );

  lmb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item       (item_out),
    .item_empty (item_empty),
    .item_pop   (item_pop),
    .res_push   (res_push),
    .res        (res_in),
    .res_full   (res_full)
  );

  lmb_queue #(
    .WIDTH ($bits(result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_result_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_out),
    .empty (empty)
  );

  assign bar_level  = res_out.bar_level;
  assign peak_level = res_out.peak_level;
  assign clip_on    = res_out.clip_on;
  assign changed    = res_out.changed;

endmodule

@@ dv/level_meter_ballistics_tb.sv @@
module level_meter_ballistics_tb;

  localparam int LEVEL_BITS      = 24;
  localparam int FRAC_BITS       = LEVEL_BITS - 2;
  localparam int TAB_DEPTH       = 64;
  localparam logic [LEVEL_BITS-1:0] FULL_SCALE = 24'h400000;
  localparam logic [1:0] MODE_K14 = 2'd3;
  localparam int RANDOM_PHASES   = 12;
  localparam int ITEMS_PER_PHASE = 110;
  localparam int PRESSURE_PHASE  = 2;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int QUIET_LIMIT     = 3000;
  localparam int DRAIN_CYCLES    = 20;

  // Predicts the meter reading for each accepted request and matches the readings
  // that come back in request order.
  class meter_scoreboard;
    lmb_pkg::cfg_t cfg;
    logic [15:0] log2_tab [TAB_DEPTH];
    int bar_q;
    int peak_q;
    int unsigned hold_cnt;
    int unsigned clip_cnt;
    bit clip_q;
    lmb_pkg::result_t due_readings [$];
    int errors;

    function new();
      logic [63:0] x;
      logic [15:0] r;
      // Fractional log2 of 1 + i/DEPTH, one bit per squaring of the mantissa.
      for (int i = 0; i < TAB_DEPTH; i++) begin
        x = (64'd1 << 30) + ((64'(i) << 30) / TAB_DEPTH);
        r = '0;
        for (int k = 0; k < 16; k++) begin
          x = (x * x) >> 30;
          r = r << 1;
          if (x >= (64'd1 << 31)) begin
            r[0] = 1'b1;
            x = x >> 1;
          end
        end
        log2_tab[i] = r;
      end
      cfg = lmb_pkg::CFG_RESET;
      bar_q = int'(cfg.floor_level);
      peak_q = bar_q;
      hold_cnt = 0;
      clip_cnt = 0;
      clip_q = 1'b0;
      errors = 0;
    endfunction

    function void set_reg(logic [lmb_pkg::REG_INDEX_BITS-1:0] idx, logic [15:0] data);
      case (idx)
        lmb_pkg::REG_METER_MODE:   cfg.meter_mode = data[1:0];
        lmb_pkg::REG_FLOOR_LEVEL:  cfg.floor_level = data;
        lmb_pkg::REG_RELEASE_STEP: cfg.release_step = data[14:0];
        lmb_pkg::REG_PEAK_HOLD:    cfg.peak_hold_ticks = data;
        lmb_pkg::REG_PEAK_DECAY:   cfg.peak_decay_step = data[14:0];
        lmb_pkg::REG_AVERAGE_COEF: cfg.average_coefficient = data;
        lmb_pkg::REG_CLIP_HOLD:    cfg.clip_hold_ticks = data;
        default: ;
      endcase
    endfunction

    function int sat16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return int'(v);
    endfunction

    function int above_floor(int v);
      return (int'(cfg.floor_level) > v) ? int'(cfg.floor_level) : v;
    endfunction

    function void log_request(logic is_clear, logic [LEVEL_BITS-1:0] lv);
      int prev_bar;
      int prev_peak;
      int db;
      int lead;
      bit prev_clip;
      logic [63:0] frac;
      logic [63:0] idx;
      longint log2_q16;
      longint acc;
      lmb_pkg::result_t r;
      prev_bar = bar_q;
      prev_peak = peak_q;
      prev_clip = clip_q;
      if (is_clear) begin
        clip_q = 1'b0;
        clip_cnt = 0;
      end else begin
        // Anything at or below a millionth of full scale reads as the floor.
        if (64'(lv) * 64'(lmb_pkg::Micro_Recip) <= 64'(FULL_SCALE)) begin
          db = int'(cfg.floor_level);
        end else begin
          lead = 0;
          for (int b = 0; b < LEVEL_BITS; b++) if (lv[b]) lead = b;
          frac = 64'(lv) - (64'd1 << lead);
          idx = (frac * TAB_DEPTH) >> lead;
          log2_q16 = longint'(lead - FRAC_BITS) * 65536 + longint'(log2_tab[idx]);
          db = above_floor(sat16((log2_q16 * longint'(lmb_pkg::DB_PER_OCTAVE_Q16)
                                  + (longint'(1) << 23)) >>> 24));
        end
        if (cfg.meter_mode == lmb_pkg::MODE_PEAK) begin
          if (db >= bar_q) bar_q = db;
          else bar_q = above_floor(bar_q - int'(cfg.release_step));
          if (db >= peak_q) begin
            peak_q = db;
            hold_cnt = cfg.peak_hold_ticks;
          end else if (hold_cnt > 0) begin
            hold_cnt--;
          end else begin
            peak_q = above_floor(peak_q - int'(cfg.peak_decay_step));
          end
        end else begin
          acc = longint'(cfg.average_coefficient) * bar_q
              + longint'(65536 - int'(cfg.average_coefficient)) * db;
          bar_q = above_floor(sat16((acc + 32768) >>> 16));
          peak_q = int'(cfg.floor_level);
        end
        if (lv >= FULL_SCALE) begin
          clip_q = 1'b1;
          clip_cnt = cfg.clip_hold_ticks;
        end else if (clip_cnt > 0) begin
          clip_cnt--;
          if (clip_cnt == 0) clip_q = 1'b0;
        end
      end
      r.bar_level = 16'(bar_q);
      r.peak_level = 16'(peak_q);
      r.clip_on = clip_q;
      r.changed = (bar_q != prev_bar) || (peak_q != prev_peak) || (clip_q != prev_clip);
      due_readings.push_back(r);
    endfunction

    function void check_field(string what, logic signed [16:0] want, logic signed [16:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
      end
    endfunction

    function void match_reading(logic signed [15:0] bar, logic signed [15:0] peak,
                                logic clip, logic chg);
      lmb_pkg::result_t want;
      if (due_readings.size() == 0) begin
        errors++;
        $display("%0t: reading expected none, got bar %0d peak %0d clip %0d changed %0d",
                 $time, bar, peak, clip, chg);
        return;
      end
      want = due_readings.pop_front();
      check_field("bar_level", want.bar_level, bar);
      check_field("peak_level", want.peak_level, peak);
      check_field("clip_on", want.clip_on, clip);
      check_field("changed", want.changed, chg);
    endfunction

    function int pending();
      return due_readings.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic op = 1'b0;
  logic [LEVEL_BITS-1:0] level = '0;
  logic pop = 1'b0;
  logic wr_en = 1'b0;
  logic [lmb_pkg::REG_INDEX_BITS-1:0] wr_index = '0;
  logic [lmb_pkg::REG_DATA_BITS-1:0] wr_data = '0;
  logic full;
  logic empty;
  logic signed [15:0] bar_level;
  logic signed [15:0] peak_level;
  logic clip_on;
  logic changed;

  meter_scoreboard sb;
  int send_idle_pct = 0;
  int take_idle_pct = 0;
  int idle_choice [4] = '{0, 10, 30, 60};
  int env_exp = 10;
  bit hold_req = 1'b0;

  level_meter_ballistics dut (
    .clk, .rst, .push, .full, .op, .level, .empty, .pop,
    .bar_level, .peak_level, .clip_on, .changed,
    .wr_en, .wr_index, .wr_data
  );

  always #1 clk = ~clk;

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len(int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 4) != 0) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic lmb_pkg::cfg_t rand_cfg();
    lmb_pkg::cfg_t c;
    c.meter_mode = ($urandom_range(0, 1) == 0) ? lmb_pkg::MODE_PEAK : 2'($urandom_range(1, 3));
    case ($urandom_range(0, 7))
      0: c.floor_level = 16'h8000;
      1: c.floor_level = '0;
      default: c.floor_level = 16'(-int'($urandom_range(1024, 30000)));
    endcase
    case ($urandom_range(0, 7))
      0: c.release_step = '0;
      1: c.release_step = 15'h7FFF;
      default: c.release_step = 15'($urandom_range(1, 600));
    endcase
    case ($urandom_range(0, 7))
      0: c.peak_hold_ticks = '0;
      1: c.peak_hold_ticks = 16'hFFFF;
      default: c.peak_hold_ticks = 16'($urandom_range(0, 40));
    endcase
    case ($urandom_range(0, 7))
      0: c.peak_decay_step = '0;
      1: c.peak_decay_step = 15'h7FFF;
      default: c.peak_decay_step = 15'($urandom_range(1, 600));
    endcase
    case ($urandom_range(0, 7))
      0: c.average_coefficient = '0;
      1: c.average_coefficient = 16'hFFFF;
      default: c.average_coefficient = 16'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0: c.clip_hold_ticks = '0;
      1: c.clip_hold_ticks = 16'hFFFF;
      default: c.clip_hold_ticks = 16'($urandom_range(0, 40));
    endcase
    return c;
  endfunction

  // Most requests follow a slowly drifting envelope so that the bar and the peak
  // rise, hold and decay; the rest are clears, overloads, near-silence and noise.
  task automatic pick_request(output logic is_clear, output logic [LEVEL_BITS-1:0] lv);
    int roll;
    roll = $urandom_range(0, 99);
    is_clear = 1'b0;
    lv = LEVEL_BITS'($urandom);
    if (roll < 6) begin
      is_clear = 1'b1;
    end else if (roll < 11) begin
      lv = LEVEL_BITS'($urandom_range(FULL_SCALE, 24'hFFFFFF));
    end else if (roll < 16) begin
      lv = LEVEL_BITS'($urandom_range(0, 6));
    end else if (roll >= 26) begin
      if ($urandom_range(0, 9) == 0) env_exp = $urandom_range(0, FRAC_BITS - 1);
      else env_exp += int'($urandom_range(0, 2)) - 1;
      if (env_exp < 0) env_exp = 0;
      if (env_exp > FRAC_BITS - 1) env_exp = FRAC_BITS - 1;
      lv = (LEVEL_BITS'(1) << env_exp) | (lv & ((LEVEL_BITS'(1) << env_exp) - 1));
    end
  endtask

  task automatic offer(input logic is_clear, input logic [LEVEL_BITS-1:0] lv);
    bit taken;
    int pause;
    push <= 1'b1;
    op <= is_clear;
    level <= lv;
    do begin
      @(negedge clk);
      taken = !full;
      @(posedge clk);
    end while (!taken);
    pause = gap_len(send_idle_pct);
    if (pause > 0) begin
      push <= 1'b0;
      repeat (pause) @(posedge clk);
    end
  endtask

  task automatic settle();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic put_reg(input logic [lmb_pkg::REG_INDEX_BITS-1:0] idx,
                         input logic [15:0] data);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic program_regs(input lmb_pkg::cfg_t c);
    put_reg(lmb_pkg::REG_METER_MODE, 16'(c.meter_mode));
    put_reg(lmb_pkg::REG_FLOOR_LEVEL, 16'(c.floor_level));
    put_reg(lmb_pkg::REG_RELEASE_STEP, 16'(c.release_step));
    put_reg(lmb_pkg::REG_PEAK_HOLD, c.peak_hold_ticks);
    put_reg(lmb_pkg::REG_PEAK_DECAY, 16'(c.peak_decay_step));
    put_reg(lmb_pkg::REG_AVERAGE_COEF, c.average_coefficient);
    put_reg(lmb_pkg::REG_CLIP_HOLD, c.clip_hold_ticks);
    wr_en <= 1'b0;
  endtask

  // Handshake signals are stable at the falling edge and hold through the next
  // rising edge, so both sides are sampled here.
  always @(negedge clk) begin
    if (!rst) begin
      if (push && !full) sb.log_request(op, level);
      if (pop && !empty) sb.match_reading(bar_level, peak_level, clip_on, changed);
    end
  end

  initial begin : receiver
    int pause;
    forever begin
      @(posedge clk);
      if (rst) begin
        pop <= 1'b0;
      end else if (hold_req) begin
        pop <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        pause = gap_len(take_idle_pct);
        if (pause == 0) begin
          pop <= 1'b1;
        end else begin
          pop <= 1'b0;
          repeat (pause - 1) @(posedge clk);
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(negedge clk);
      if ((push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
    end
    $display("level_meter_ballistics test failed");
    $finish;
  end

  initial begin : stimulus
    lmb_pkg::cfg_t setup;
    logic is_clear;
    logic [LEVEL_BITS-1:0] lv;
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings (VU averaging): floor threshold, extremes, overload, clears.
    send_idle_pct = 30;
    take_idle_pct = 30;
    offer(1'b0, 24'h000000);
    offer(1'b0, 24'h000004);
    offer(1'b0, 24'h000005);
    offer(1'b0, 24'h000001);
    offer(1'b0, 24'hFFFFFF);
    offer(1'b0, 24'h3FFFFF);
    offer(1'b0, 24'h400000);
    offer(1'b1, 24'hABCDEF);
    offer(1'b1, 24'h000000);
    settle();

    // Peak mode at the lowest floor; a zero clip hold keeps the flag lit until cleared.
    setup.meter_mode = lmb_pkg::MODE_PEAK;
    setup.floor_level = 16'h8000;
    setup.release_step = 15'd1;
    setup.peak_hold_ticks = 16'd2;
    setup.peak_decay_step = 15'h7FFF;
    setup.average_coefficient = 16'd0;
    setup.clip_hold_ticks = 16'd0;
    program_regs(setup);
    offer(1'b0, 24'hFFFFFF);
    offer(1'b0, 24'h000008);
    offer(1'b0, 24'h000008);
    offer(1'b0, 24'h000008);
    offer(1'b0, 24'h000008);
    offer(1'b0, 24'h000100);
    offer(1'b1, 24'h555555);
    offer(1'b0, 24'h2AAAAA);
    settle();

    // Averaging with a positive floor written as is; stored values are left alone
    // until the next tick applies it.
    setup.meter_mode = MODE_K14;
    setup.floor_level = 16'sd256;
    setup.release_step = 15'd0;
    setup.peak_hold_ticks = 16'hFFFF;
    setup.peak_decay_step = 15'd0;
    setup.average_coefficient = 16'hFFFF;
    setup.clip_hold_ticks = 16'hFFFF;
    program_regs(setup);
    offer(1'b0, 24'h400000);
    offer(1'b0, 24'h800000);
    offer(1'b0, 24'h000064);
    offer(1'b1, 24'h000000);
    offer(1'b0, 24'h000002);
    settle();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      program_regs(rand_cfg());
      if (ph == 0) begin
        send_idle_pct = 0;
        take_idle_pct = 0;
      end else begin
        send_idle_pct = idle_choice[$urandom_range(0, 3)];
        take_idle_pct = idle_choice[$urandom_range(0, 3)];
      end
      // The receiver stops for a long stretch while requests keep coming.
      if (ph == PRESSURE_PHASE) begin
        send_idle_pct = 0;
        hold_req = 1'b1;
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick_request(is_clear, lv);
        offer(is_clear, lv);
      end
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("level_meter_ballistics test passed");
    end else begin
      $display("level_meter_ballistics test failed");
    end
    $finish;
  end

endmodule

@@ level_meter_ballistics.f @@
rtl/lmb_pkg.sv
rtl/lmb_queue.sv
rtl/lmb_front.sv
rtl/lmb_back.sv
rtl/level_meter_ballistics.sv
dv/level_meter_ballistics_tb.sv
